[sv/mhpq_pkg.sv]
// ----------------------------------------------------------------------------
// Min-heap priority queue package
// Shared widths, operation and status codes, and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package mhpq_pkg;

    localparam int VAL_W     = 32;
    localparam int STAT_W    = 2;
    localparam int CNT_OUT_W = 7;

    typedef enum logic {
        FUNC_INSERT = 1'b0,
        FUNC_REMOVE = 1'b1
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic start;
        logic up_read;
        logic up_move;
        logic dn_load;
        logic dn_read;
        logic dn_move;
        logic put_val;
        logic resp_load;
    } t_cmd;

    typedef struct packed {
        logic ins_go;
        logic rem_go;
        logic pos_root;
        logic up_greater;
        logic dn_empty;
        logic no_left;
        logic dn_greater;
        logic out_free;
    } t_stat;

endpackage

[sv/mhpq_if.sv]
// ----------------------------------------------------------------------------
// Min-heap priority queue channels
// Request channel (operation and value) and response channel (removed value,
// status and entry count), each with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface mhpq_req_if;
    logic                              valid;
    logic                              ready;
    logic                              func;
    logic signed [mhpq_pkg::VAL_W-1:0] value;

    modport source (output valid, output func, output value, input ready);
    modport sink (input valid, input func, input value, output ready);
endinterface

interface mhpq_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [mhpq_pkg::VAL_W-1:0]     out_value;
    logic        [mhpq_pkg::STAT_W-1:0]    status;
    logic        [mhpq_pkg::CNT_OUT_W-1:0] entry_count;

    modport source (output valid, output out_value, output status, output entry_count,
                    input ready);
    modport sink (input valid, input out_value, input status, input entry_count,
                  output ready);
endinterface

[sv/min_heap_priority_queue_unit.sv]
// ----------------------------------------------------------------------------
// Min-heap priority queue unit
// Binary min-heap of signed 32-bit values held in a RAM, with insert and
// remove-minimum requests and one response per request.
//
//   Channel    Dir  Payload                                   Transfer
//   i_req_if   in   func, value                               valid & ready
//   o_rsp_if   out  out_value, status, entry_count            valid & ready
//
// An insert starts its hole at the end of the heap and climbs one level for
// each parent that is greater than its value, stopping at the root. A remove
// takes the root as its result, moves the last entry into the root hole and
// sinks it below each smaller child until a leaf. An empty remove or a dropped
// insert goes straight to its response, and a waiting response can hold the
// unit before it returns to idle. Each level is a RAM read followed by a
// compare and write. One request is worked on at a time. The response
// register lets the next request start while a response waits. Reset empties
// the heap at once; the RAM itself is not cleared.
// ----------------------------------------------------------------------------
module min_heap_priority_queue_unit #(
    parameter int CAPACITY = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mhpq_req_if.sink    i_req_if,
    mhpq_rsp_if.source  o_rsp_if
);

    mhpq_pkg::t_cmd  cmd;
    mhpq_pkg::t_stat stat;

    mhpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req_if.valid),
        .o_in_ready (i_req_if.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    mhpq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_func        (i_req_if.func),
        .i_value       (i_req_if.value),
        .o_out_valid   (o_rsp_if.valid),
        .i_out_ready   (o_rsp_if.ready),
        .o_out_value   (o_rsp_if.out_value),
        .o_status      (o_rsp_if.status),
        .o_entry_count (o_rsp_if.entry_count)
    );

endmodule

[sv/mhpq_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

[sv/mhpq_ctrl.sv]
// ----------------------------------------------------------------------------
// Min-heap priority queue controller
// Sequences one request at a time through sift-up or sift-down and the
// handoff of its response into the output register.
// ----------------------------------------------------------------------------
module mhpq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  mhpq_pkg::t_stat i_stat,
    output mhpq_pkg::t_cmd  o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_UP_RD  = 7'b0000010,
        S_UP_CMP = 7'b0000100,
        S_DN_LD  = 7'b0001000,
        S_DN_RD  = 7'b0010000,
        S_DN_CMP = 7'b0100000,
        S_RESP   = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    if (i_stat.ins_go) begin
                        n_state = S_UP_RD;
                    end else if (i_stat.rem_go) begin
                        n_state = S_DN_LD;
                    end else begin
                        n_state = S_RESP;
                    end
                end
            end
            S_UP_RD: begin
                if (i_stat.pos_root) begin
                    o_cmd.put_val = 1'b1;
                    n_state       = S_RESP;
                end else begin
                    o_cmd.up_read = 1'b1;
                    n_state       = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (i_stat.up_greater) begin
                    o_cmd.up_move = 1'b1;
                    n_state       = S_UP_RD;
                end else begin
                    o_cmd.put_val = 1'b1;
                    n_state       = S_RESP;
                end
            end
            S_DN_LD: begin
                o_cmd.dn_load = 1'b1;
                n_state       = i_stat.dn_empty ? S_RESP : S_DN_RD;
            end
            S_DN_RD: begin
                if (i_stat.no_left) begin
                    o_cmd.put_val = 1'b1;
                    n_state       = S_RESP;
                end else begin
                    o_cmd.dn_read = 1'b1;
                    n_state       = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                if (i_stat.dn_greater) begin
                    o_cmd.dn_move = 1'b1;
                    n_state       = S_DN_RD;
                end else begin
                    o_cmd.put_val = 1'b1;
                    n_state       = S_RESP;
                end
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.resp_load = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[sv/mhpq_dp.sv]
// ----------------------------------------------------------------------------
// Min-heap priority queue datapath
// Heap RAM, entry count, moving value and hole position, and the output
// register. The sifts move a hole instead of swapping pairs of entries.
// ----------------------------------------------------------------------------
module mhpq_dp #(
    parameter int CAPACITY = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  mhpq_pkg::t_cmd                        i_cmd,
    output mhpq_pkg::t_stat                       o_stat,
    input  logic                                  i_func,
    input  logic signed [mhpq_pkg::VAL_W-1:0]     i_value,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [mhpq_pkg::VAL_W-1:0]     o_out_value,
    output logic        [mhpq_pkg::STAT_W-1:0]    o_status,
    output logic        [mhpq_pkg::CNT_OUT_W-1:0] o_entry_count
);

    localparam int AW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int CIW = AW + 2;

    logic        [CW-1:0]              r_count;
    logic        [AW-1:0]              r_pos;
    logic signed [mhpq_pkg::VAL_W-1:0] r_val;
    logic signed [mhpq_pkg::VAL_W-1:0] r_result;
    mhpq_pkg::t_status                 r_status;

    logic                              ram_we;
    logic        [AW-1:0]              ram_waddr;
    logic        [mhpq_pkg::VAL_W-1:0] ram_wdata;
    logic        [AW-1:0]              ram_raddr_a;
    logic        [AW-1:0]              ram_raddr_b;
    logic        [mhpq_pkg::VAL_W-1:0] ram_rdata_a;
    logic        [mhpq_pkg::VAL_W-1:0] ram_rdata_b;

    logic                              is_insert;
    logic                              full;
    logic                              empty;
    logic        [CW-1:0]              cnt_dec;
    logic        [AW-1:0]              parent;
    logic        [CIW-1:0]             left_idx;
    logic        [CIW-1:0]             right_idx;
    logic        [CIW-1:0]             cnt_ext;
    logic                              has_right;
    logic                              take_right;
    logic signed [mhpq_pkg::VAL_W-1:0] pick_val;
    logic        [AW-1:0]              pick_idx;
    logic        [CW+mhpq_pkg::CNT_OUT_W-1:0] cnt_out;

    assign is_insert  = (i_func == mhpq_pkg::FUNC_INSERT);
    assign full       = (r_count == CW'(CAPACITY));
    assign empty      = (r_count == '0);
    assign cnt_dec    = r_count - CW'(1);
    assign parent     = (r_pos - AW'(1)) >> 1;
    assign left_idx   = {1'b0, r_pos, 1'b1};
    assign right_idx  = left_idx + CIW'(1);
    assign cnt_ext    = CIW'(r_count);
    assign has_right  = (right_idx < cnt_ext);
    assign take_right = has_right && ($signed(ram_rdata_b) < $signed(ram_rdata_a));
    assign pick_val   = take_right ? $signed(ram_rdata_b) : $signed(ram_rdata_a);
    assign pick_idx   = take_right ? right_idx[AW-1:0] : left_idx[AW-1:0];
    assign cnt_out    = {{mhpq_pkg::CNT_OUT_W{1'b0}}, r_count};

    always_comb begin
        o_stat            = '0;
        o_stat.ins_go     = is_insert && !full;
        o_stat.rem_go     = !is_insert && !empty;
        o_stat.pos_root   = (r_pos == '0);
        o_stat.up_greater = ($signed(ram_rdata_a) > r_val);
        o_stat.dn_empty   = empty;
        o_stat.no_left    = (left_idx >= cnt_ext);
        o_stat.dn_greater = (r_val > pick_val);
        o_stat.out_free   = !o_out_valid || i_out_ready;
    end

    always_comb begin
        ram_we      = i_cmd.up_move || i_cmd.dn_move || i_cmd.put_val;
        ram_waddr   = r_pos;
        ram_wdata   = r_val;
        ram_raddr_a = '0;
        ram_raddr_b = '0;
        if (i_cmd.up_move) begin
            ram_wdata = ram_rdata_a;
        end else if (i_cmd.dn_move) begin
            ram_wdata = pick_val;
        end
        if (i_cmd.start) begin
            ram_raddr_b = cnt_dec[AW-1:0];
        end else if (i_cmd.up_read) begin
            ram_raddr_a = parent;
        end else if (i_cmd.dn_read) begin
            ram_raddr_a = left_idx[AW-1:0];
            ram_raddr_b = right_idx[AW-1:0];
        end
    end

    mhpq_ram #(
        .WIDTH (mhpq_pkg::VAL_W),
        .DEPTH (CAPACITY)
    ) u_heap_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (ram_raddr_a),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_a (ram_rdata_a),
        .o_rdata_b (ram_rdata_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                if (is_insert && !full) begin
                    r_count <= r_count + CW'(1);
                end else if (!is_insert && !empty) begin
                    r_count <= cnt_dec;
                end
            end
            if (i_cmd.resp_load) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_val    <= i_value;
            r_result <= '0;
            r_pos    <= is_insert ? r_count[AW-1:0] : '0;
            if (is_insert && full) begin
                r_status <= mhpq_pkg::ST_FULL;
            end else if (!is_insert && empty) begin
                r_status <= mhpq_pkg::ST_EMPTY;
            end else begin
                r_status <= mhpq_pkg::ST_OK;
            end
        end
        if (i_cmd.dn_load) begin
            r_result <= $signed(ram_rdata_a);
            r_val    <= $signed(ram_rdata_b);
        end
        if (i_cmd.up_move) begin
            r_pos <= parent;
        end
        if (i_cmd.dn_move) begin
            r_pos <= pick_idx;
        end
        if (i_cmd.resp_load) begin
            o_out_value   <= r_result;
            o_status      <= r_status;
            o_entry_count <= cnt_out[mhpq_pkg::CNT_OUT_W-1:0];
        end
    end

endmodule

[sv/mhpq_checker.sv]
// ----------------------------------------------------------------------------
// Min-heap priority queue checker
// Port-level properties of the unit, attached to it by a bind statement.
// ----------------------------------------------------------------------------
module mhpq_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_req_valid,
    input logic                                  i_req_ready,
    input logic                                  i_rsp_valid,
    input logic                                  i_rsp_ready,
    input logic signed [mhpq_pkg::VAL_W-1:0]     i_out_value,
    input logic        [mhpq_pkg::STAT_W-1:0]    i_status,
    input logic        [mhpq_pkg::CNT_OUT_W-1:0] i_entry_count
);

    // Requests are never accepted back to back: ready drops after an acceptance.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request accepted back to back");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_out_value)
            && $stable(i_status) && $stable(i_entry_count))
        else $error("stalled response changed");

    a_empty_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_status == mhpq_pkg::ST_EMPTY |->
            i_out_value == '0 && i_entry_count == '0)
        else $error("empty remove reported a value or entries");

    a_full_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_status == mhpq_pkg::ST_FULL |-> i_out_value == '0)
        else $error("dropped insert reported a value");

endmodule

bind min_heap_priority_queue_unit mhpq_checker u_mhpq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req_if.valid),
    .i_req_ready   (i_req_if.ready),
    .i_rsp_valid   (o_rsp_if.valid),
    .i_rsp_ready   (o_rsp_if.ready),
    .i_out_value   (o_rsp_if.out_value),
    .i_status      (o_rsp_if.status),
    .i_entry_count (o_rsp_if.entry_count)
);
